FILE: design/contiguous_segment_allocator_defines.svh
// Assertion macros for the contiguous segment allocator.
`ifndef CONTIGUOUS_SEGMENT_ALLOCATOR_DEFINES_SVH
`define CONTIGUOUS_SEGMENT_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define CSA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define CSA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define CSA_ASSERT(lbl, prop, msg)
`define CSA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: design/csa_pkg.sv
// Shared types and codes of the contiguous segment allocator.
package csa_pkg;

    localparam int MAX_RESULTS = 16;

    localparam logic [2:0] KIND_INIT    = 3'd0;
    localparam logic [2:0] KIND_REQUEST = 3'd1;
    localparam logic [2:0] KIND_RELEASE = 3'd2;
    localparam logic [2:0] KIND_COMPACT = 3'd3;
    localparam logic [2:0] KIND_REPORT  = 3'd4;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_NOFIT = 2'd1;
    localparam logic [1:0] STATUS_NOPID = 2'd2;
    localparam logic [1:0] STATUS_FULL  = 2'd3;

    localparam logic [1:0] STRAT_FIRST = 2'd0;
    localparam logic [1:0] STRAT_BEST  = 2'd1;
    localparam logic [1:0] STRAT_WORST = 2'd2;
    localparam logic [1:0] STRAT_BAD   = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_REQ, S_DECIDE, S_SHIFT, S_ALLOC,
        S_REL, S_REL_END, S_CMP, S_CMP_END, S_REP
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP, DP_LOAD, DP_INIT, DP_SCAN, DP_SHIFT, DP_SPLIT, DP_ALLOC,
        DP_REL, DP_REL_END, DP_CMP, DP_CMP_END, DP_REP
    } t_dp_op;

    typedef enum logic [1:0] {
        EM_PLAIN, EM_INIT, EM_ALLOC, EM_REPORT
    } t_emit;

    typedef struct packed {
        t_dp_op     op;
        logic       emit;
        t_emit      em;
        logic [1:0] st;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] in_kind;
        logic       bad_req;
        logic       scan_stop;
        logic       found;
        logic       split;
        logic       full;
        logic       shift_done;
        logic       rd_last;
        logic       hit;
        logic       rep_last;
        logic       out_free;
    } t_dp_stat;

endpackage

FILE: design/contiguous_segment_allocator.sv
// Top level of the contiguous segment allocator.
//  channel | direction | beat
//  s_axis  | in        | tuser kind; tdata pid, size, strategy
//  m_axis  | out       | tdata status, seg_start, seg_end, seg_owner, seg_free; tlast
//  cfg     | in        | memory_size, written on valid and ready
// After accept: init writes one hole; request scans, then shifts entries when it splits a hole;
// release and compact walk every table entry; report sends one result beat per entry, up to MAX_RESULTS.
// The per-item cost is set by the single table write port walked by the sequencer.
// Output beats wait in a result register while the sequencer stalls on m_axis_tready.
// Reset is synchronous and gives one hole over the whole address range.
`include "contiguous_segment_allocator_defines.svh"
module contiguous_segment_allocator
    import csa_pkg::*;
#(
    parameter int NUM_SEGMENTS = 16,
    parameter int ADDR_BITS    = 16,
    parameter int PID_BITS     = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // pid, size, strategy
    input  logic [((PID_BITS+ADDR_BITS+3)+7)/8*8-1:0] s_axis_tdata,
    // kind
    input  logic [2:0]           s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // status, seg_start, seg_end, seg_owner, seg_free
    output logic [((2*ADDR_BITS+PID_BITS+3)+7)/8*8-1:0] m_axis_tdata,
    output logic                 m_axis_tlast,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [ADDR_BITS:0]   i_cfg_data
);

    localparam int OTW = ((2*ADDR_BITS+PID_BITS+3)+7)/8*8;
    localparam int SZ_LO = PID_BITS;
    localparam int ST_LO = PID_BITS + ADDR_BITS + 1;

    t_dp_cmd              w_cmd;
    t_dp_stat             w_stat;
    logic [1:0]           w_status;
    logic [ADDR_BITS-1:0] w_start, w_end;
    logic [PID_BITS-1:0]  w_owner;
    logic                 w_free;

    assign o_cfg_ready = 1'b1;

    csa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    csa_dp #(
        .NUM_SEGMENTS (NUM_SEGMENTS),
        .ADDR_BITS    (ADDR_BITS),
        .PID_BITS     (PID_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_kind      (s_axis_tuser),
        .i_pid       (s_axis_tdata[PID_BITS-1:0]),
        .i_size      (s_axis_tdata[ST_LO-1:SZ_LO]),
        .i_strat     (s_axis_tdata[ST_LO+1:ST_LO]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_status    (w_status),
        .o_start     (w_start),
        .o_end       (w_end),
        .o_owner     (w_owner),
        .o_free      (w_free),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = OTW'({w_free, w_owner, w_end, w_start, w_status});

    `CSA_ASSERT(a_emit_slot_free, w_cmd.emit |-> (!m_axis_tvalid || m_axis_tready), "result overwritten")
    `CSA_ASSERT(a_accept_loads, (s_axis_tvalid && s_axis_tready) |-> (w_cmd.op == DP_LOAD), "accept without load")
    `CSA_ASSERT(a_ready_idle_ops, s_axis_tready |-> (w_cmd.op == DP_NOP || w_cmd.op == DP_LOAD), "table op while ready")

endmodule

FILE: design/csa_ctrl.sv
// Controller state machine that sequences the table operations.
module csa_ctrl
    import csa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '{op: DP_NOP, emit: 1'b0, em: EM_PLAIN, st: STATUS_OK};
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = DP_LOAD;
                    priority case (i_stat.in_kind)
                        KIND_INIT:    n_state = S_INIT;
                        KIND_REQUEST: n_state = S_REQ;
                        KIND_RELEASE: n_state = S_REL;
                        KIND_COMPACT: n_state = S_CMP;
                        KIND_REPORT:  n_state = S_REP;
                        default:      n_state = S_IDLE;
                    endcase
                end
            end
            S_INIT: begin
                if (i_stat.out_free) begin
                    o_cmd   = '{op: DP_INIT, emit: 1'b1, em: EM_INIT, st: STATUS_OK};
                    n_state = S_IDLE;
                end
            end
            S_REQ: begin
                if (i_stat.bad_req) begin
                    if (i_stat.out_free) begin
                        o_cmd   = '{op: DP_NOP, emit: 1'b1, em: EM_PLAIN, st: STATUS_NOFIT};
                        n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.op = DP_SCAN;
                    if (i_stat.scan_stop) begin
                        n_state = S_DECIDE;
                    end
                end
            end
            S_DECIDE: begin
                if (!i_stat.found || (i_stat.split && i_stat.full)) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.st   = i_stat.found ? STATUS_FULL : STATUS_NOFIT;
                        n_state    = S_IDLE;
                    end
                end else if (i_stat.split) begin
                    n_state = S_SHIFT;
                end else begin
                    n_state = S_ALLOC;
                end
            end
            S_SHIFT: begin
                if (i_stat.shift_done) begin
                    o_cmd.op = DP_SPLIT;
                    n_state  = S_ALLOC;
                end else begin
                    o_cmd.op = DP_SHIFT;
                end
            end
            S_ALLOC: begin
                if (i_stat.out_free) begin
                    o_cmd   = '{op: DP_ALLOC, emit: 1'b1, em: EM_ALLOC, st: STATUS_OK};
                    n_state = S_IDLE;
                end
            end
            S_REL: begin
                o_cmd.op = DP_REL;
                if (i_stat.rd_last) begin
                    n_state = S_REL_END;
                end
            end
            S_REL_END: begin
                if (i_stat.out_free) begin
                    o_cmd.op   = DP_REL_END;
                    o_cmd.emit = 1'b1;
                    o_cmd.st   = i_stat.hit ? STATUS_OK : STATUS_NOPID;
                    n_state    = S_IDLE;
                end
            end
            S_CMP: begin
                o_cmd.op = DP_CMP;
                if (i_stat.rd_last) begin
                    n_state = S_CMP_END;
                end
            end
            S_CMP_END: begin
                if (i_stat.out_free) begin
                    o_cmd   = '{op: DP_CMP_END, emit: 1'b1, em: EM_PLAIN, st: STATUS_OK};
                    n_state = S_IDLE;
                end
            end
            S_REP: begin
                if (i_stat.out_free) begin
                    o_cmd = '{op: DP_REP, emit: 1'b1, em: EM_REPORT, st: STATUS_OK};
                    if (i_stat.rep_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

FILE: design/csa_dp.sv
// Segment table, scan registers and result register.
module csa_dp
    import csa_pkg::*;
#(
    parameter int NUM_SEGMENTS = 16,
    parameter int ADDR_BITS    = 16,
    parameter int PID_BITS     = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    input  logic                 i_cfg_we,
    input  logic [ADDR_BITS:0]   i_cfg_data,
    input  logic [2:0]           i_kind,
    input  logic [PID_BITS-1:0]  i_pid,
    input  logic [ADDR_BITS:0]   i_size,
    input  logic [1:0]           i_strat,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [1:0]           o_status,
    output logic [ADDR_BITS-1:0] o_start,
    output logic [ADDR_BITS-1:0] o_end,
    output logic [PID_BITS-1:0]  o_owner,
    output logic                 o_free,
    output logic                 o_last
);

    localparam int IW = $clog2(NUM_SEGMENTS);
    localparam int CW = $clog2(NUM_SEGMENTS + 1);
    localparam int SW = ADDR_BITS + 1;
    localparam logic [SW-1:0] LIMIT = {1'b1, {ADDR_BITS{1'b0}}};

    logic [ADDR_BITS-1:0] r_start [NUM_SEGMENTS];
    logic [ADDR_BITS-1:0] r_end   [NUM_SEGMENTS];
    logic [PID_BITS-1:0]  r_owner [NUM_SEGMENTS];
    logic [NUM_SEGMENTS-1:0] r_used;

    logic [SW-1:0]        r_msize;
    logic [CW-1:0]        r_count, n_count;
    logic [IW-1:0]        r_idx, n_idx;
    logic [CW-1:0]        r_w, n_w;
    logic [CW-1:0]        r_j, n_j;
    logic [IW-1:0]        r_found, n_found;
    logic                 r_found_vld, n_found_vld;
    logic [SW-1:0]        r_best, n_best;
    logic [ADDR_BITS-1:0] r_fstart, n_fstart;
    logic                 r_hit, n_hit;
    logic                 r_prev_used, n_prev_used;
    logic [SW-1:0]        r_next, n_next;
    logic [PID_BITS-1:0]  r_pid;
    logic [SW-1:0]        r_size;
    logic [1:0]           r_strat;
    logic                 r_out_valid;

    // table write port
    logic                 we, we_end_only;
    logic [IW-1:0]        wa;
    logic [ADDR_BITS-1:0] wd_start, wd_end;
    logic [PID_BITS-1:0]  wd_owner;
    logic                 wd_used;

    logic [SW-1:0]        ms;
    logic [ADDR_BITS-1:0] ms_m1;
    logic [CW-1:0]        j_m1, w_m1, found_p1;
    logic [IW-1:0]        rd_addr;
    logic [ADDR_BITS-1:0] c_start, c_end;
    logic [PID_BITS-1:0]  c_owner;
    logic                 c_used;
    logic [SW-1:0]        hs;
    logic                 fits, better, split, own_hit, used_n, rep_last;
    logic [ADDR_BITS-1:0] len, alloc_end;
    logic [31:0]          rep_n;
    logic                 hole_ok;

    logic [1:0]           e_status;
    logic [ADDR_BITS-1:0] e_start, e_end;
    logic [PID_BITS-1:0]  e_owner;
    logic                 e_free, e_last;

    always_comb begin
        if (r_msize == '0) begin
            ms = SW'(1);
        end else if (r_msize > LIMIT) begin
            ms = LIMIT;
        end else begin
            ms = r_msize;
        end
    end
    assign ms_m1 = ADDR_BITS'(ms - SW'(1));

    assign j_m1     = r_j - CW'(1);
    assign w_m1     = r_w - CW'(1);
    assign found_p1 = CW'(r_found) + CW'(1);
    assign rd_addr  = (i_cmd.op == DP_SHIFT) ? j_m1[IW-1:0] : r_idx;

    assign c_start = r_start[rd_addr];
    assign c_end   = r_end[rd_addr];
    assign c_owner = r_owner[rd_addr];
    assign c_used  = r_used[rd_addr];

    assign hs     = SW'(c_end) - SW'(c_start) + SW'(1);
    assign fits   = !c_used && (r_size <= hs);
    assign better = !r_found_vld || (r_strat == STRAT_BEST && hs < r_best)
                  || (r_strat == STRAT_WORST && hs > r_best);
    assign split  = r_size < r_best;

    assign own_hit = c_used && (c_owner == r_pid);
    assign used_n  = c_used && !own_hit;
    assign len     = c_end - c_start;
    assign alloc_end = ADDR_BITS'(SW'(r_fstart) + r_size - SW'(1));

    assign rep_n    = (32'(r_count) > 32'(MAX_RESULTS)) ? 32'(MAX_RESULTS) : 32'(r_count);
    assign rep_last = (32'(r_idx) + 32'd1) == rep_n;
    assign hole_ok  = (r_next < ms) && (r_w < CW'(NUM_SEGMENTS));

    assign o_stat.in_kind    = i_kind;
    assign o_stat.bad_req    = (r_size == '0) || (r_strat == STRAT_BAD);
    assign o_stat.scan_stop  = (CW'(r_idx) == r_count - CW'(1))
                             || (fits && r_strat == STRAT_FIRST);
    assign o_stat.found      = r_found_vld;
    assign o_stat.split      = split;
    assign o_stat.full       = r_count >= CW'(NUM_SEGMENTS);
    assign o_stat.shift_done = r_j == found_p1;
    assign o_stat.rd_last    = CW'(r_idx) == r_count - CW'(1);
    assign o_stat.hit        = r_hit;
    assign o_stat.rep_last   = rep_last;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        n_count     = r_count;
        n_idx       = r_idx;
        n_w         = r_w;
        n_j         = r_j;
        n_found     = r_found;
        n_found_vld = r_found_vld;
        n_best      = r_best;
        n_fstart    = r_fstart;
        n_hit       = r_hit;
        n_prev_used = r_prev_used;
        n_next      = r_next;
        we          = 1'b0;
        we_end_only = 1'b0;
        wa          = '0;
        wd_start    = c_start;
        wd_end      = c_end;
        wd_owner    = c_owner;
        wd_used     = c_used;
        unique case (i_cmd.op)
            DP_LOAD: begin
                n_idx       = '0;
                n_w         = '0;
                n_j         = r_count;
                n_found_vld = 1'b0;
                n_hit       = 1'b0;
                n_next      = '0;
            end
            DP_INIT: begin
                we       = 1'b1;
                wd_start = '0;
                wd_end   = ms_m1;
                wd_owner = '0;
                wd_used  = 1'b0;
                n_count  = CW'(1);
            end
            DP_SCAN: begin
                if (fits && better) begin
                    n_found     = r_idx;
                    n_found_vld = 1'b1;
                    n_best      = hs;
                    n_fstart    = c_start;
                end
                n_idx = r_idx + IW'(1);
            end
            DP_SHIFT: begin
                we  = 1'b1;
                wa  = r_j[IW-1:0];
                n_j = j_m1;
            end
            DP_SPLIT: begin
                // remainder hole right after the new block
                we       = 1'b1;
                wa       = found_p1[IW-1:0];
                wd_start = ADDR_BITS'(SW'(r_fstart) + r_size);
                wd_end   = r_end[r_found];
                wd_owner = '0;
                wd_used  = 1'b0;
            end
            DP_ALLOC: begin
                we       = 1'b1;
                wa       = r_found;
                wd_start = r_fstart;
                wd_end   = alloc_end;
                wd_owner = r_pid;
                wd_used  = 1'b1;
                n_count  = r_count + CW'(split);
            end
            DP_REL: begin
                if (own_hit) begin
                    n_hit = 1'b1;
                end
                if (r_w != '0 && !r_prev_used && !used_n) begin
                    // fold this hole into the previous one
                    we          = 1'b1;
                    we_end_only = 1'b1;
                    wa          = w_m1[IW-1:0];
                end else begin
                    we          = 1'b1;
                    wa          = r_w[IW-1:0];
                    wd_owner    = used_n ? c_owner : '0;
                    wd_used     = used_n;
                    n_prev_used = used_n;
                    n_w         = r_w + CW'(1);
                end
                n_idx = r_idx + IW'(1);
            end
            DP_REL_END: begin
                n_count = r_w;
            end
            DP_CMP: begin
                if (c_used) begin
                    we       = 1'b1;
                    wa       = r_w[IW-1:0];
                    wd_start = r_next[ADDR_BITS-1:0];
                    wd_end   = ADDR_BITS'(r_next + SW'(len));
                    n_next   = r_next + SW'(len) + SW'(1);
                    n_w      = r_w + CW'(1);
                end
                n_idx = r_idx + IW'(1);
            end
            DP_CMP_END: begin
                if (r_w != '0) begin
                    if (hole_ok) begin
                        we       = 1'b1;
                        wa       = r_w[IW-1:0];
                        wd_start = r_next[ADDR_BITS-1:0];
                        wd_end   = ms_m1;
                        wd_owner = '0;
                        wd_used  = 1'b0;
                        n_count  = r_w + CW'(1);
                    end else begin
                        n_count = r_w;
                    end
                end
            end
            DP_REP: begin
                n_idx = r_idx + IW'(1);
            end
            DP_NOP: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        e_status = i_cmd.st;
        e_start  = '0;
        e_end    = '0;
        e_owner  = '0;
        e_free   = 1'b0;
        e_last   = 1'b1;
        unique case (i_cmd.em)
            EM_INIT: begin
                e_end  = ms_m1;
                e_free = 1'b1;
            end
            EM_ALLOC: begin
                e_start = r_fstart;
                e_end   = alloc_end;
                e_owner = r_pid;
            end
            EM_REPORT: begin
                e_start = c_start;
                e_end   = c_end;
                e_owner = c_used ? c_owner : '0;
                e_free  = !c_used;
                e_last  = rep_last;
            end
            EM_PLAIN: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msize     <= LIMIT;
            r_count     <= CW'(1);
            r_used      <= '0;
            r_start[0]  <= '0;
            r_end[0]    <= '1;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_w         <= '0;
            r_j         <= '0;
            r_found_vld <= 1'b0;
            r_hit       <= 1'b0;
            r_prev_used <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_msize <= i_cfg_data;
            end
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_w         <= n_w;
            r_j         <= n_j;
            r_found_vld <= n_found_vld;
            r_hit       <= n_hit;
            r_prev_used <= n_prev_used;
            if (we) begin
                r_end[wa] <= wd_end;
                if (!we_end_only) begin
                    r_start[wa] <= wd_start;
                    r_owner[wa] <= wd_owner;
                    r_used[wa]  <= wd_used;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_found  <= n_found;
        r_best   <= n_best;
        r_fstart <= n_fstart;
        r_next   <= n_next;
        if (i_cmd.op == DP_LOAD) begin
            r_pid   <= i_pid;
            r_size  <= i_size;
            r_strat <= i_strat;
        end
        if (i_cmd.emit) begin
            o_status <= e_status;
            o_start  <= e_start;
            o_end    <= e_end;
            o_owner  <= e_owner;
            o_free   <= e_free;
            o_last   <= e_last;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: tb/tb_contiguous_segment_allocator.sv
// Testbench for the contiguous segment allocator: directed table, then random phases.
`timescale 1ns / 1ps
module tb_contiguous_segment_allocator;
    import csa_pkg::*;

    localparam int NSEG = 16;
    localparam logic [2:0] KIND_RSVD_LO = 3'd5;
    localparam logic [2:0] KIND_RSVD_HI = 3'd7;

    typedef struct {
        logic [1:0]  status;
        logic [15:0] seg_start;
        logic [15:0] seg_end;
        logic [7:0]  seg_owner;
        logic        seg_free;
        logic        last;
    } t_seg_beat;

    typedef struct {
        logic [2:0]  kind;
        logic [7:0]  pid;
        logic [16:0] size;
        logic [1:0]  strat;
        bit          typed;
        logic [1:0]  want_st;
    } t_op_row;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // pid[7:0], size[24:8], strategy[26:25]
    logic [2:0]  s_axis_tuser = '0;   // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    // status[1:0], seg_start[17:2], seg_end[33:18], seg_owner[41:34], seg_free[42]
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [16:0] i_cfg_data = '0;

    contiguous_segment_allocator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    initial forever #4 i_clk = ~i_clk;

    // shadow allocator state
    logic [16:0] mem_cfg = 17'd65536;
    logic [15:0] seg_lo [NSEG];
    logic [15:0] seg_hi [NSEG];
    logic [7:0]  seg_pid [NSEG];
    bit          seg_busy [NSEG];
    int          seg_cnt;

    t_seg_beat   pending_beats[$];
    int          err_cnt = 0;
    int          hold_req_cnt = 0;
    int          hold_done_cnt = 0;
    int          hold_left = 0;
    int          rx_cyc = 0;
    bit          no_idle = 0;

    function automatic int managed_units();
        int m;
        m = mem_cfg;
        if (m < 1) m = 1;
        if (m > 65536) m = 65536;
        return m;
    endfunction

    function automatic void clear_table();
        for (int i = 0; i < NSEG; i++) begin
            seg_lo[i] = 0; seg_hi[i] = 0; seg_pid[i] = 0; seg_busy[i] = 0;
        end
        seg_hi[0] = 16'(managed_units() - 1);
        seg_cnt = 1;
    endfunction

    function automatic void push_beat(logic [1:0] st, int lo, int hi, logic [7:0] own,
                                      logic fr, logic lst);
        t_seg_beat b;
        b.status = st; b.seg_start = 16'(lo); b.seg_end = 16'(hi);
        b.seg_owner = own; b.seg_free = fr; b.last = lst;
        pending_beats.push_back(b);
    endfunction

    function automatic void move_seg(int d, int s);
        seg_lo[d] = seg_lo[s]; seg_hi[d] = seg_hi[s];
        seg_pid[d] = seg_pid[s]; seg_busy[d] = seg_busy[s];
    endfunction

    function automatic void alloc_model(logic [7:0] p, logic [16:0] sz, logic [1:0] st);
        int found, best, hs;
        found = -1; best = 0;
        if (sz == 0 || st == STRAT_BAD) begin
            push_beat(STATUS_NOFIT, 0, 0, 0, 0, 1);
            return;
        end
        for (int i = 0; i < seg_cnt; i++) begin
            if (seg_busy[i]) continue;
            hs = int'(seg_hi[i]) - int'(seg_lo[i]) + 1;
            if (sz > hs) continue;
            if (found < 0) begin
                found = i; best = hs;
                if (st == STRAT_FIRST) break;
            end else if ((st == STRAT_BEST && hs < best) || (st == STRAT_WORST && hs > best)) begin
                found = i; best = hs;
            end
        end
        if (found < 0) begin
            push_beat(STATUS_NOFIT, 0, 0, 0, 0, 1);
            return;
        end
        if (sz < best) begin
            if (seg_cnt >= NSEG) begin
                push_beat(STATUS_FULL, 0, 0, 0, 0, 1);
                return;
            end
            for (int j = seg_cnt; j > found + 1; j--) move_seg(j, j - 1);
            seg_lo[found+1] = 16'(int'(seg_lo[found]) + int'(sz));
            seg_hi[found+1] = seg_hi[found];
            seg_pid[found+1] = 0;
            seg_busy[found+1] = 0;
            seg_cnt++;
        end
        seg_hi[found] = 16'(int'(seg_lo[found]) + int'(sz) - 1);
        seg_pid[found] = p;
        seg_busy[found] = 1;
        push_beat(STATUS_OK, seg_lo[found], seg_hi[found], p, 0, 1);
    endfunction

    function automatic void free_model(logic [7:0] p);
        int w;
        bit hit;
        w = 0; hit = 0;
        for (int r = 0; r < seg_cnt; r++)
            if (seg_busy[r] && seg_pid[r] == p) begin
                seg_busy[r] = 0; seg_pid[r] = 0; hit = 1;
            end
        // merge runs of adjacent holes
        for (int r = 0; r < seg_cnt; r++) begin
            if (w > 0 && !seg_busy[w-1] && !seg_busy[r]) seg_hi[w-1] = seg_hi[r];
            else begin
                if (w != r) move_seg(w, r);
                w++;
            end
        end
        seg_cnt = w;
        push_beat(hit ? STATUS_OK : STATUS_NOPID, 0, 0, 0, 0, 1);
    endfunction

    function automatic void compact_model();
        int w, nxt, len, ms;
        w = 0; nxt = 0; ms = managed_units();
        for (int r = 0; r < seg_cnt; r++) begin
            if (!seg_busy[r]) continue;
            len = int'(seg_hi[r]) - int'(seg_lo[r]);
            seg_lo[w] = 16'(nxt);
            seg_hi[w] = 16'(nxt + len);
            seg_pid[w] = seg_pid[r];
            seg_busy[w] = 1;
            nxt = nxt + len + 1;
            w++;
        end
        if (w > 0) begin
            if (nxt <= ms - 1 && w < NSEG) begin
                seg_lo[w] = 16'(nxt); seg_hi[w] = 16'(ms - 1);
                seg_pid[w] = 0; seg_busy[w] = 0;
                w++;
            end
            seg_cnt = w;
        end
        push_beat(STATUS_OK, 0, 0, 0, 0, 1);
    endfunction

    function automatic void predict_item(logic [2:0] k, logic [7:0] p, logic [16:0] sz,
                                         logic [1:0] st);
        case (k)
            KIND_INIT: begin
                clear_table();
                push_beat(STATUS_OK, 0, seg_hi[0], 0, 1, 1);
            end
            KIND_REQUEST: alloc_model(p, sz, st);
            KIND_RELEASE: free_model(p);
            KIND_COMPACT: compact_model();
            KIND_REPORT:
                for (int i = 0; i < seg_cnt && i < MAX_RESULTS; i++)
                    push_beat(STATUS_OK, seg_lo[i], seg_hi[i], seg_busy[i] ? seg_pid[i] : 8'd0,
                              !seg_busy[i], i + 1 == seg_cnt || i + 1 == MAX_RESULTS);
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    task automatic check_beat();
        t_seg_beat w;
        if (pending_beats.size() == 0) begin
            report_mismatch("unexpected beat", m_axis_tdata, 0);
            return;
        end
        w = pending_beats.pop_front();
        if (m_axis_tdata[1:0] !== w.status) report_mismatch("status", m_axis_tdata[1:0], w.status);
        if (m_axis_tdata[17:2] !== w.seg_start)
            report_mismatch("seg_start", m_axis_tdata[17:2], w.seg_start);
        if (m_axis_tdata[33:18] !== w.seg_end)
            report_mismatch("seg_end", m_axis_tdata[33:18], w.seg_end);
        if (m_axis_tdata[41:34] !== w.seg_owner)
            report_mismatch("seg_owner", m_axis_tdata[41:34], w.seg_owner);
        if (m_axis_tdata[42] !== w.seg_free) report_mismatch("seg_free", m_axis_tdata[42], w.seg_free);
        if (m_axis_tlast !== w.last) report_mismatch("tlast", m_axis_tlast, w.last);
    endtask

    // receiver: own stall pattern, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            rx_cyc++;
            if (m_axis_tvalid && m_axis_tready) check_beat();
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 0;
            end else if (hold_done_cnt != hold_req_cnt) begin
                hold_done_cnt = hold_req_cnt;
                hold_left = 400;
                m_axis_tready <= 0;
            end else if (rx_cyc[7]) begin
                m_axis_tready <= 1;
            end else begin
                m_axis_tready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    int burst_left = 0;

    task automatic send_item(logic [2:0] k, logic [7:0] p, logic [16:0] sz, logic [1:0] st);
        if (!no_idle && burst_left == 0) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0) burst_left--;
        s_axis_tvalid <= 1;
        s_axis_tuser <= k;
        s_axis_tdata <= {5'd0, st, sz, p};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_item(k, p, sz, st);
    endtask

    task automatic wait_results();
        s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (pending_beats.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_mem_size(logic [16:0] v);
        wait_results();
        // kinds with no result may still be in flight
        repeat (80) @(posedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
        mem_cfg = v;
    endtask

    task automatic random_item(int ms);
        int r;
        logic [2:0]  k;
        logic [7:0]  p;
        logic [16:0] sz;
        logic [1:0]  st;
        r = $urandom_range(0, 99);
        if (r < 50) k = KIND_REQUEST;
        else if (r < 72) k = KIND_RELEASE;
        else if (r < 80) k = KIND_COMPACT;
        else if (r < 91) k = KIND_REPORT;
        else if (r < 96) k = KIND_INIT;
        else k = 3'($urandom_range(KIND_RSVD_LO, KIND_RSVD_HI));
        p = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
        r = $urandom_range(0, 19);
        if (r == 0) sz = 0;
        else if (r < 3) sz = 17'($urandom);
        else if (r == 3) sz = 17'(ms);
        else sz = 17'($urandom_range(1, ms / 4 + 1));
        st = ($urandom_range(0, 15) == 0) ? STRAT_BAD : 2'($urandom_range(0, 2));
        send_item(k, p, sz, st);
    endtask

    t_op_row dir_rows[] = '{
        '{KIND_REPORT,  8'd0,   17'd0,      STRAT_FIRST, 0, STATUS_OK},
        '{KIND_REQUEST, 8'd1,   17'd0,      STRAT_FIRST, 1, STATUS_NOFIT},
        '{KIND_REQUEST, 8'd1,   17'd10,     STRAT_BAD,   1, STATUS_NOFIT},
        '{KIND_REQUEST, 8'd1,   17'h1FFFF,  STRAT_WORST, 1, STATUS_NOFIT},
        '{KIND_RELEASE, 8'd9,   17'd0,      STRAT_FIRST, 1, STATUS_NOPID},
        '{KIND_COMPACT, 8'd0,   17'd0,      STRAT_FIRST, 1, STATUS_OK},
        '{KIND_REQUEST, 8'd255, 17'd65536,  STRAT_WORST, 1, STATUS_OK},
        '{KIND_REPORT,  8'd0,   17'd0,      STRAT_FIRST, 0, STATUS_OK},
        '{KIND_REQUEST, 8'd3,   17'd1,      STRAT_FIRST, 1, STATUS_NOFIT},
        '{KIND_RELEASE, 8'd255, 17'd0,      STRAT_FIRST, 1, STATUS_OK},
        '{KIND_REQUEST, 8'd0,   17'd100,    STRAT_FIRST, 0, STATUS_OK},
        '{KIND_REQUEST, 8'd2,   17'd300,    STRAT_BEST,  0, STATUS_OK},
        '{KIND_REQUEST, 8'd0,   17'd50,     STRAT_WORST, 0, STATUS_OK},
        '{KIND_RELEASE, 8'd2,   17'h1FFFF,  STRAT_BAD,   0, STATUS_OK},
        '{KIND_REQUEST, 8'd170, 17'd20,     STRAT_BEST,  0, STATUS_OK},
        '{KIND_REQUEST, 8'd85,  17'h0AAAA,  STRAT_FIRST, 0, STATUS_OK},
        '{KIND_REPORT,  8'd0,   17'd0,      STRAT_FIRST, 0, STATUS_OK},
        '{KIND_RELEASE, 8'd0,   17'd0,      STRAT_FIRST, 0, STATUS_OK},
        '{KIND_COMPACT, 8'd0,   17'd0,      STRAT_FIRST, 0, STATUS_OK},
        '{KIND_REPORT,  8'd0,   17'd0,      STRAT_FIRST, 0, STATUS_OK},
        '{KIND_RSVD_LO, 8'd1,   17'd1,      STRAT_FIRST, 0, STATUS_OK},
        '{KIND_RSVD_HI, 8'd1,   17'd1,      STRAT_FIRST, 0, STATUS_OK},
        '{KIND_INIT,    8'd0,   17'd0,      STRAT_FIRST, 1, STATUS_OK},
        '{KIND_REPORT,  8'd0,   17'd0,      STRAT_FIRST, 0, STATUS_OK}
    };

    logic [16:0] mem_plan[] = '{17'd0, 17'd1, 17'd16, 17'd64, 17'h1FFFF, 17'd200, 17'd65536};

    initial begin
        clear_table();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].kind, dir_rows[i].pid, dir_rows[i].size, dir_rows[i].strat);
            if (dir_rows[i].typed) pending_beats[$].status = dir_rows[i].want_st;
        end
        foreach (mem_plan[ph]) begin
            write_mem_size(mem_plan[ph]);
            no_idle = (ph == 4);
            send_item(KIND_INIT, 0, 0, STRAT_FIRST);
            for (int n = 0; n < 36; n++) begin
                if (ph == 3 && n == 5) hold_req_cnt++;
                if (n == 20) wait_results();
                random_item(managed_units());
            end
        end
        wait_results();
        repeat (100) @(posedge i_clk);
        if (err_cnt == 0 && pending_beats.size() == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #40ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
